@@ hdl/rc_link_frame_parser_top_assert.svh @@
// Assertion macros used by the frame parser RTL.
`ifndef RC_LINK_FRAME_PARSER_TOP_ASSERT_SVH
`define RC_LINK_FRAME_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RCFP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rc link frame parser: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RCFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rc link frame parser: next-cycle check failed");

`endif

@@ hdl/rclfp_pkg.sv @@
package rclfp_pkg;

    // Frame store geometry.
    localparam int FRAME_BYTES = 64;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);
    localparam int MAX_LEN     = FRAME_BYTES - 2;
    localparam int MIN_LEN     = 3;

    // Packed channel area: store positions 3..24.
    localparam logic [ADDR_W-1:0] CH_FIRST_ADDR = ADDR_W'(3);
    localparam logic [ADDR_W-1:0] CRC_FIRST_ADDR = ADDR_W'(2);
    localparam logic [3:0] LAST_CHANNEL = 4'd15;
    localparam logic [3:0] FAILSAFE_CHANNEL = 4'd2;

    localparam logic [7:0] CRC_POLY = 8'hD5;

    // Channel scaling constants.
    localparam logic signed [11:0] RAW_CENTER = 12'sd992;
    localparam logic signed [12:0] PWM_CENTER = 13'sd1500;
    localparam logic signed [12:0] PWM_MIN    = 13'sd1000;
    localparam logic signed [12:0] PWM_MAX    = 13'sd2000;

    // Result kinds.
    localparam logic [1:0] KIND_STATUS   = 2'd0;
    localparam logic [1:0] KIND_CHANNEL  = 2'd1;
    localparam logic [1:0] KIND_FAILSAFE = 2'd2;

    // Input actions.
    localparam logic ACT_BYTE    = 1'b0;
    localparam logic ACT_TIMEOUT = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_SYNC     = 2'd0;
    localparam logic [1:0] REG_RC_TYPE  = 2'd1;
    localparam logic [1:0] REG_TIMEOUT  = 2'd2;
    localparam logic [1:0] REG_FAILSAFE = 2'd3;

    // One byte of CRC-8, MSB first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // (raw - 992) * 5 / 8 + 1500, truncating toward zero, clamped to 1000..2000.
    function automatic logic [10:0] map_channel(input logic [10:0] raw);
        logic signed [11:0] d;
        logic signed [13:0] m;
        logic signed [13:0] q;
        logic signed [12:0] v;
        d = $signed({1'b0, raw}) - RAW_CENTER;
        m = ($signed({{2{d[11]}}, d}) <<< 2) + $signed({{2{d[11]}}, d});
        if (m < 0) begin
            q = (m + 14'sd7) >>> 3;
        end else begin
            q = m >>> 3;
        end
        v = 13'(q) + PWM_CENTER;
        if (v < PWM_MIN) begin
            v = PWM_MIN;
        end else if (v > PWM_MAX) begin
            v = PWM_MAX;
        end
        return v[10:0];
    endfunction

endpackage

@@ hdl/rc_link_frame_parser_top.sv @@
// Channel  | Direction | Handshake                      | Payload
// in       | input     | i_in_valid / o_in_stall        | i_action, i_data_byte, i_time_ms
// out      | output    | o_out_valid / i_out_stall      | o_kind, o_frame_accepted,
//          |           |                                | o_channel_index, o_channel_value,
//          |           |                                | o_link_connected, o_last_of_run
// cfg      | input     | i_cfg_we                       | i_cfg_index, i_cfg_data
//
// A byte or timeout beat that gives one result passes through S_EMIT and is then ready again.
// A byte that closes a frame runs the CRC over length-1 store bytes, then reads 22 store
// bytes one at a time and maps and outputs each channel in turn; the single store read
// port sets this pace.
// Synchronous active-low reset clears control state, the valid flags and the store's valid bits.
// A stall on out holds the sequencer; o_in_stall is high until the last result is registered.
module rc_link_frame_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [7:0]  i_data_byte,
    input  logic [31:0] i_time_ms,
    // Output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic        o_frame_accepted,
    output logic [3:0]  o_channel_index,
    output logic [10:0] o_channel_value,
    output logic        o_link_connected,
    output logic        o_last_of_run,
    // Configuration port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import rclfp_pkg::*;

`include "rc_link_frame_parser_top_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_CRC,
        S_CHECK,
        S_UNP_RD,
        S_UNP_ACC,
        S_UNP_MAP,
        S_EMIT
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [7:0]  r_sync_value;
    logic [7:0]  r_rc_type_code;
    logic [15:0] r_link_timeout_ms;
    logic [10:0] r_failsafe_throttle;

    // Frame hunt and link state.
    logic [ADDR_W-1:0] r_pos;
    logic [7:0]        r_len;
    logic [7:0]        r_type;
    logic [7:0]        r_crc_byte;
    logic [31:0]       r_time;
    logic [31:0]       r_last_good_time;
    logic              r_link_up;

    // Sequencer working registers.
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_left;
    logic              r_pend;
    logic [7:0]        r_crc;
    logic [18:0]       r_acc;
    logic [4:0]        r_nbits;
    logic [3:0]        r_ch;

    // Result waiting to enter the output register.
    logic [1:0]  r_res_kind;
    logic        r_res_acc;
    logic [3:0]  r_res_idx;
    logic [10:0] r_res_val;
    logic        r_res_last;

    // Output register.
    logic        r_out_valid;
    logic [1:0]  r_out_kind;
    logic        r_out_acc;
    logic [3:0]  r_out_idx;
    logic [10:0] r_out_val;
    logic        r_out_link;
    logic        r_out_last;

    // Frame store and its valid bits.
    logic [7:0]             r_mem [FRAME_BYTES];
    logic [FRAME_BYTES-1:0] r_vld;
    logic [7:0]             r_mem_q;
    logic                   r_mem_q_vld;
    logic [7:0]             rd_data;

    logic              in_acc;
    logic              out_free;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    // Frame hunt next values for an accepted byte.
    logic [ADDR_W-1:0] n_pos;
    logic [7:0]        n_len;
    logic              n_frame_done;
    logic [ADDR_W:0]   pos_inc;
    logic              timed_out;
    logic [31:0]       silence;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign rd_data  = r_mem_q_vld ? r_mem_q : 8'd0;

    assign silence   = i_time_ms - r_last_good_time;
    assign timed_out = r_link_up && (silence > {16'd0, r_link_timeout_ms});

    // Byte parser: position, length and store write for an accepted byte.
    always_comb begin
        n_pos        = r_pos;
        n_len        = r_len;
        n_frame_done = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = r_pos;
        pos_inc      = {1'b0, r_pos} + (ADDR_W+1)'(1);
        if (in_acc && (i_action == ACT_BYTE)) begin
            priority if (r_pos == '0) begin
                if (i_data_byte == r_sync_value) begin
                    mem_we = 1'b1;
                    n_pos  = ADDR_W'(1);
                end
            end else if (r_pos == ADDR_W'(1)) begin
                n_len = i_data_byte;
                if ((i_data_byte > 8'(MAX_LEN)) || (i_data_byte < 8'(MIN_LEN))) begin
                    n_pos = '0;
                end else begin
                    mem_we = 1'b1;
                    n_pos  = ADDR_W'(2);
                end
            end else begin
                mem_we = 1'b1;
                if ({2'b0, pos_inc} >= ({1'b0, r_len} + 9'd2)) begin
                    n_pos        = '0;
                    n_frame_done = 1'b1;
                end else begin
                    n_pos = pos_inc[ADDR_W-1:0];
                end
            end
        end
    end

    // Read address comes from the sequencer.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_addr;
        if ((r_state == S_CRC) && (r_left != '0)) begin
            rd_en = 1'b1;
        end else if (r_state == S_UNP_RD) begin
            rd_en = 1'b1;
        end
    end

    // Frame store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= i_data_byte;
        end
        if (rd_en) begin
            r_mem_q <= r_mem[rd_addr];
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_value        <= 8'd200;
            r_rc_type_code      <= 8'd22;
            r_link_timeout_ms   <= 16'd500;
            r_failsafe_throttle <= 11'd1000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SYNC:     r_sync_value        <= i_cfg_data[7:0];
                REG_RC_TYPE:  r_rc_type_code      <= i_cfg_data[7:0];
                REG_TIMEOUT:  r_link_timeout_ms   <= i_cfg_data;
                REG_FAILSAFE: r_failsafe_throttle <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // Sequencer, link state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_pos            <= '0;
            r_len            <= 8'd0;
            r_last_good_time <= 32'd0;
            r_link_up        <= 1'b0;
            r_vld            <= '0;
            r_mem_q_vld      <= 1'b0;
            r_pend           <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            // The output register empties when its beat is taken.
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (mem_we) begin
                r_vld[mem_waddr] <= 1'b1;
            end
            if (rd_en) begin
                r_mem_q_vld <= r_vld[rd_addr];
            end
            r_pos <= n_pos;
            r_len <= n_len;

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_time     <= i_time_ms;
                        r_crc_byte <= i_data_byte;
                        r_res_kind <= KIND_STATUS;
                        r_res_acc  <= 1'b0;
                        r_res_idx  <= 4'd0;
                        r_res_val  <= 11'd0;
                        r_res_last <= 1'b1;
                        if (i_action == ACT_TIMEOUT) begin
                            if (timed_out) begin
                                r_link_up  <= 1'b0;
                                r_res_kind <= KIND_FAILSAFE;
                                r_res_idx  <= FAILSAFE_CHANNEL;
                                r_res_val  <= r_failsafe_throttle;
                            end
                            r_state <= S_EMIT;
                        end else begin
                            if (r_pos == CRC_FIRST_ADDR) begin
                                r_type <= i_data_byte;
                            end
                            if (n_frame_done) begin
                                r_addr  <= CRC_FIRST_ADDR;
                                r_left  <= ADDR_W'(r_len - 8'd1);
                                r_pend  <= 1'b0;
                                r_crc   <= 8'd0;
                                r_state <= S_CRC;
                            end else begin
                                r_state <= S_EMIT;
                            end
                        end
                    end
                end

                // One store byte into the CRC each cycle, reads running one ahead.
                S_CRC: begin
                    if (r_left != '0) begin
                        r_addr <= r_addr + ADDR_W'(1);
                        r_left <= r_left - ADDR_W'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend) begin
                        r_crc <= crc8_byte(r_crc, rd_data);
                    end
                    if ((r_left == '0) && !r_pend) begin
                        r_state <= S_CHECK;
                    end
                end

                // Good RC frame starts the unpack, anything else is a status result.
                S_CHECK: begin
                    if ((r_crc == r_crc_byte) && (r_type == r_rc_type_code)) begin
                        r_last_good_time <= r_time;
                        r_link_up        <= 1'b1;
                        r_addr           <= CH_FIRST_ADDR;
                        r_acc            <= 19'd0;
                        r_nbits          <= 5'd0;
                        r_ch             <= 4'd0;
                        r_state          <= S_UNP_RD;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end

                S_UNP_RD: begin
                    r_addr  <= r_addr + ADDR_W'(1);
                    r_state <= S_UNP_ACC;
                end

                // Append the byte above the bits still held.
                S_UNP_ACC: begin
                    r_acc   <= r_acc | (19'(rd_data) << r_nbits);
                    r_nbits <= r_nbits + 5'd8;
                    if ((r_nbits + 5'd8) >= 5'd11) begin
                        r_state <= S_UNP_MAP;
                    end else begin
                        r_state <= S_UNP_RD;
                    end
                end

                // Take the low 11 bits as the next channel and scale it.
                S_UNP_MAP: begin
                    r_res_kind <= KIND_CHANNEL;
                    r_res_acc  <= 1'b1;
                    r_res_idx  <= r_ch;
                    r_res_val  <= map_channel(r_acc[10:0]);
                    r_res_last <= (r_ch == LAST_CHANNEL);
                    r_acc      <= r_acc >> 11;
                    r_nbits    <= r_nbits - 5'd11;
                    r_state    <= S_EMIT;
                end

                // Move the prepared result into the output register.
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= r_res_kind;
                        r_out_acc   <= r_res_acc;
                        r_out_idx   <= r_res_idx;
                        r_out_val   <= r_res_val;
                        r_out_link  <= r_link_up;
                        r_out_last  <= r_res_last;
                        if (r_res_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_ch <= r_ch + 4'd1;
                            if (r_nbits >= 5'd11) begin
                                r_state <= S_UNP_MAP;
                            end else begin
                                r_state <= S_UNP_RD;
                            end
                        end
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_out_kind;
    assign o_frame_accepted = r_out_acc;
    assign o_channel_index  = r_out_idx;
    assign o_channel_value  = r_out_val;
    assign o_link_connected = r_out_link;
    assign o_last_of_run    = r_out_last;

    // A failsafe result always reports a dropped link.
    `RCFP_ASSERT_NOW(a_failsafe_down, o_out_valid && (o_kind == KIND_FAILSAFE), !o_link_connected)
    // Channel results come only from an accepted frame, with the link up.
    `RCFP_ASSERT_NOW(a_frame_link_up, o_out_valid && (o_kind == KIND_CHANNEL),
                     o_frame_accepted && o_link_connected)
    // An accepted beat makes the block busy on the next cycle.
    `RCFP_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    // A channel is only cut once eleven bits are held.
    `RCFP_ASSERT_NOW(a_enough_bits, r_state == S_UNP_MAP, r_nbits >= 5'd11)

endmodule
